// ----- hdl/bebs_pkg.sv -----
// bebs_pkg: shared types, constants and coefficient lookup for the
// biquad envelope band statistics block; no dependencies
package bebs_pkg;

    localparam int RMS_WINDOW_LOG2_DEF = 6;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int COUNT_BITS_DEF      = 32;

    localparam int LIMIT_W   = 17;
    localparam int SHIFT_W   = 4;
    localparam int FILT_W    = 17;
    localparam int RMS_W     = 16;
    localparam int BAND_W    = 2;
    localparam int COEF_W    = 14;
    localparam int SQ_W      = 33;
    localparam int SQACC_W   = 40;
    localparam int ROOT_IN_W = 32;
    localparam int Q_SHIFT   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 3;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOUD_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_SHIFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SHIFT = 3'd4;

    localparam logic [LIMIT_W-1:0] QUIET_LIMIT_RST   = 17'd800;
    localparam logic [LIMIT_W-1:0] NORMAL_LIMIT_RST  = 17'd2400;
    localparam logic [LIMIT_W-1:0] LOUD_LIMIT_RST    = 17'd3600;
    localparam logic [SHIFT_W-1:0] ATTACK_SHIFT_RST  = 4'd2;
    localparam logic [SHIFT_W-1:0] RELEASE_SHIFT_RST = 4'd6;

    localparam logic signed [COEF_W-1:0] COEF_B0 = 14'sd275;
    localparam logic signed [COEF_W-1:0] COEF_B1 = 14'sd550;
    localparam logic signed [COEF_W-1:0] COEF_B2 = 14'sd275;
    localparam logic signed [COEF_W-1:0] COEF_A1 = 14'sd4682;
    localparam logic signed [COEF_W-1:0] COEF_A2 = -14'sd1692;

    localparam logic [BAND_W-1:0] BAND_QUIET   = 2'd0;
    localparam logic [BAND_W-1:0] BAND_NORMAL  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_LOUD    = 2'd2;
    localparam logic [BAND_W-1:0] BAND_CLIPPED = 2'd3;

    typedef struct packed {
        logic [LIMIT_W-1:0] quiet_limit;
        logic [LIMIT_W-1:0] normal_limit;
        logic [LIMIT_W-1:0] loud_limit;
        logic [SHIFT_W-1:0] atk_shift;
        logic [SHIFT_W-1:0] rel_shift;
    } cfg_t;

    // coefficient for each multiply step of the filter sequence
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [STEP_W-1:0] step);
        logic signed [COEF_W-1:0] c;
        case (step)
            3'd0:    c = COEF_B0;
            3'd1:    c = COEF_B1;
            3'd2:    c = COEF_B2;
            3'd3:    c = COEF_A1;
            3'd4:    c = COEF_A2;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/bebs_queue.sv -----
// bebs_queue: short sample queue between the stream input and the back end
// depends on bebs_pkg
module bebs_queue
    import bebs_pkg::*;
#(
    parameter int DATA_W = SAMPLE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_pop,
    output logic [DATA_W-1:0] rd_data
);

    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0]  mem_reg [QUEUE_DEPTH];
    logic [ADDR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_wr, do_rd;

    assign wr_ready = (count_reg != COUNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + ADDR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/bebs_root.sv -----
// bebs_root: iterative 32-bit integer square root, one result bit per cycle
// depends on bebs_pkg
module bebs_root
    import bebs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [ROOT_IN_W-1:0] value,
    output logic                 done,
    output logic [RMS_W-1:0]     result
);

    localparam int CNT_W = $clog2(RMS_W);

    logic [ROOT_IN_W-1:0] rem_reg, res_reg, probe_reg;
    logic [ROOT_IN_W-1:0] trial;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, done_reg;

    assign trial  = res_reg + probe_reg;
    assign done   = done_reg;
    assign result = res_reg[RMS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == CNT_W'(RMS_W - 1))) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= value;
            res_reg   <= '0;
            probe_reg <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
            cnt_reg   <= '0;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + probe_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            probe_reg <= probe_reg >> 2;
            cnt_reg   <= cnt_reg + CNT_W'(1);
        end
    end

endmodule

// ----- hdl/bebs_back.sv -----
// bebs_back: sequencer that filters, follows the envelope, counts bands,
// accumulates squares and holds the result register; uses bebs_pkg, bebs_root
module bebs_back
    import bebs_pkg::*;
#(
    parameter int RMS_WINDOW_LOG2 = RMS_WINDOW_LOG2_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   q_valid,
    input  logic [SAMPLE_BITS-1:0] q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FILT_W-1:0]      out_filtered,
    output logic [LIMIT_W-1:0]     out_envelope,
    output logic [BAND_W-1:0]      out_band,
    output logic [COUNT_BITS-1:0]  out_count,
    output logic [RMS_W-1:0]       out_rms,
    output logic                   out_fresh
);

    localparam int OP_W   = (SAMPLE_BITS > FILT_W) ? SAMPLE_BITS : FILT_W;
    localparam int PROD_W = OP_W + COEF_W;
    localparam int MAC_W  = OP_W + COEF_W + 1;
    localparam int WIN_W  = RMS_WINDOW_LOG2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_ENV  = 3'd2;
    localparam logic [2:0] ST_BAND = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic signed [MAC_W-1:0] FILT_HI = MAC_W'(65535);
    localparam logic signed [MAC_W-1:0] FILT_LO = -MAC_W'(65536);

    logic [2:0]                    state_reg;
    logic [STEP_W-1:0]             step_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg, xd1_reg, xd2_reg;
    logic signed [FILT_W-1:0]      yd1_reg, yd2_reg, y_reg;
    logic signed [PROD_W-1:0]      prod_reg, prod;
    logic signed [MAC_W-1:0]       mac_reg, mac_sum, mac_q;
    logic signed [OP_W-1:0]        opnd;
    logic signed [FILT_W-1:0]      y_sat;
    logic [LIMIT_W-1:0]            env_reg, env_next, mag;
    logic [SQ_W-1:0]               sq_reg;
    logic signed [2*FILT_W-1:0]    sq_full;
    logic [SQACC_W-1:0]            sqacc_reg, sqacc_sum;
    logic [WIN_W-1:0]              win_reg;
    logic [COUNT_BITS-1:0]         hist_reg [4];
    logic [COUNT_BITS-1:0]         cnt_reg, cnt_next;
    logic [BAND_W-1:0]             band_reg, band_next;
    logic [RMS_W-1:0]              rms_reg;
    logic                          fresh_reg;
    logic                          root_start, root_done;
    logic [ROOT_IN_W-1:0]          root_in;
    logic [RMS_W-1:0]              root_res;
    logic                          out_valid_reg;
    logic [FILT_W-1:0]             o_filt_reg;
    logic [LIMIT_W-1:0]            o_env_reg;
    logic [BAND_W-1:0]             o_band_reg;
    logic [COUNT_BITS-1:0]         o_cnt_reg;
    logic [RMS_W-1:0]              o_rms_reg;
    logic                          o_fresh_reg;
    logic                          out_load;

    bebs_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .value   (root_in),
        .done    (root_done),
        .result  (root_res)
    );

    // operand for the current multiply step
    always_comb begin
        case (step_reg)
            3'd0:    opnd = OP_W'(x_reg);
            3'd1:    opnd = OP_W'(xd1_reg);
            3'd2:    opnd = OP_W'(xd2_reg);
            3'd3:    opnd = OP_W'(yd1_reg);
            3'd4:    opnd = OP_W'(yd2_reg);
            default: opnd = '0;
        endcase
    end

    assign prod    = PROD_W'(coef_at(step_reg)) * PROD_W'(opnd);
    assign mac_sum = mac_reg + MAC_W'(prod_reg);
    assign mac_q   = mac_sum >>> Q_SHIFT;

    always_comb begin
        if (mac_q > FILT_HI) begin
            y_sat = FILT_W'(FILT_HI);
        end else if (mac_q < FILT_LO) begin
            y_sat = FILT_W'(FILT_LO);
        end else begin
            y_sat = mac_q[FILT_W-1:0];
        end
    end

    // envelope follower
    always_comb begin
        mag = y_reg[FILT_W-1] ? LIMIT_W'(-y_reg) : LIMIT_W'(y_reg);
        if (mag > env_reg) begin
            env_next = env_reg + ((mag - env_reg) >> cfg.atk_shift);
        end else begin
            env_next = env_reg - ((env_reg - mag) >> cfg.rel_shift);
        end
    end

    assign sq_full = (2*FILT_W)'(y_reg) * (2*FILT_W)'(y_reg);

    always_comb begin
        if (env_reg < cfg.quiet_limit) begin
            band_next = BAND_QUIET;
        end else if (env_reg < cfg.normal_limit) begin
            band_next = BAND_NORMAL;
        end else if (env_reg < cfg.loud_limit) begin
            band_next = BAND_LOUD;
        end else begin
            band_next = BAND_CLIPPED;
        end
    end

    assign cnt_next   = hist_reg[band_next] + COUNT_BITS'(1);
    assign sqacc_sum  = sqacc_reg + SQACC_W'(sq_reg);
    assign root_in    = ROOT_IN_W'(sqacc_sum >> RMS_WINDOW_LOG2);
    assign root_start = (state_reg == ST_BAND) && (&win_reg);
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            xd1_reg       <= '0;
            xd2_reg       <= '0;
            yd1_reg       <= '0;
            yd2_reg       <= '0;
            env_reg       <= '0;
            sqacc_reg     <= '0;
            win_reg       <= '0;
            rms_reg       <= '0;
            fresh_reg     <= 1'b0;
            hist_reg[0]   <= '0;
            hist_reg[1]   <= '0;
            hist_reg[2]   <= '0;
            hist_reg[3]   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_MAC;
                        step_reg  <= '0;
                    end
                end
                ST_MAC: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(5)) begin
                        xd2_reg   <= xd1_reg;
                        xd1_reg   <= x_reg;
                        yd2_reg   <= yd1_reg;
                        yd1_reg   <= y_sat;
                        state_reg <= ST_ENV;
                    end
                end
                ST_ENV: begin
                    env_reg   <= env_next;
                    state_reg <= ST_BAND;
                end
                ST_BAND: begin
                    hist_reg[band_next] <= cnt_next;
                    win_reg             <= win_reg + WIN_W'(1);
                    if (&win_reg) begin
                        sqacc_reg <= '0;
                        fresh_reg <= 1'b1;
                        state_reg <= ST_ROOT;
                    end else begin
                        sqacc_reg <= sqacc_sum;
                        fresh_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_ROOT: begin
                    if (root_done) begin
                        rms_reg   <= root_res;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            x_reg    <= q_data;
            mac_reg  <= '0;
            prod_reg <= '0;
        end
        if (state_reg == ST_MAC) begin
            prod_reg <= prod;
            mac_reg  <= mac_sum;
            if (step_reg == STEP_W'(5)) begin
                y_reg <= y_sat;
            end
        end
        if (state_reg == ST_ENV) begin
            sq_reg <= sq_full[SQ_W-1:0];
        end
        if (state_reg == ST_BAND) begin
            band_reg <= band_next;
            cnt_reg  <= cnt_next;
        end
        if (out_load) begin
            o_filt_reg  <= y_reg;
            o_env_reg   <= env_reg;
            o_band_reg  <= band_reg;
            o_cnt_reg   <= cnt_reg;
            o_rms_reg   <= rms_reg;
            o_fresh_reg <= fresh_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_filtered = o_filt_reg;
    assign out_envelope = o_env_reg;
    assign out_band     = o_band_reg;
    assign out_count    = o_cnt_reg;
    assign out_rms      = o_rms_reg;
    assign out_fresh    = o_fresh_reg;

endmodule

// ----- hdl/biquad_envelope_band_stats.sv -----
// biquad_envelope_band_stats: top level with configuration registers, input
// queue and processing back end; uses bebs_pkg, bebs_queue, bebs_back
//
//   channel   ports                         contents
//   input     s_tvalid s_tready s_tdata     sample
//   result    m_tvalid m_tready m_tdata     filtered envelope band band_count rms
//             m_tuser                       rms_fresh
//   config    cfg_valid cfg_ready           cfg_index cfg_data, always ready
//
// an item in the back end pops the queue, steps through the shared filter multiplier,
// then does envelope, band and result load; a window-closing item also waits
// for the bit-serial square root. a four-entry queue takes samples while the
// back end works or the result register is stalled. reset is synchronous and
// clears filter state, envelope, histogram and accumulator; config takes its defaults.
module biquad_envelope_band_stats
    import bebs_pkg::*;
#(
    parameter int RMS_WINDOW_LOG2 = RMS_WINDOW_LOG2_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // filtered, envelope, band, band_count, rms_value
    output logic [((FILT_W+LIMIT_W+BAND_W+COUNT_BITS+RMS_W+7)/8)*8-1:0] m_tdata,
    output logic                   m_tuser, // rms_fresh
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LIMIT_W-1:0]     cfg_data
);

    localparam int M_TDATA_W = ((FILT_W + LIMIT_W + BAND_W + COUNT_BITS + RMS_W + 7) / 8) * 8;

    cfg_t                   cfg_reg;
    logic                   q_valid, q_pop;
    logic [SAMPLE_BITS-1:0] q_data;
    logic [FILT_W-1:0]      r_filtered;
    logic [LIMIT_W-1:0]     r_envelope;
    logic [BAND_W-1:0]      r_band;
    logic [COUNT_BITS-1:0]  r_count;
    logic [RMS_W-1:0]       r_rms;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quiet_limit  <= QUIET_LIMIT_RST;
            cfg_reg.normal_limit <= NORMAL_LIMIT_RST;
            cfg_reg.loud_limit   <= LOUD_LIMIT_RST;
            cfg_reg.atk_shift    <= ATTACK_SHIFT_RST;
            cfg_reg.rel_shift    <= RELEASE_SHIFT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_QUIET_LIMIT:   cfg_reg.quiet_limit  <= cfg_data;
                REG_NORMAL_LIMIT:  cfg_reg.normal_limit <= cfg_data;
                REG_LOUD_LIMIT:    cfg_reg.loud_limit   <= cfg_data;
                REG_ATTACK_SHIFT:  cfg_reg.atk_shift    <= cfg_data[SHIFT_W-1:0];
                REG_RELEASE_SHIFT: cfg_reg.rel_shift    <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    bebs_queue #(
        .DATA_W (SAMPLE_BITS)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (s_tdata[SAMPLE_BITS-1:0]),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    bebs_back #(
        .RMS_WINDOW_LOG2 (RMS_WINDOW_LOG2),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_filtered (r_filtered),
        .out_envelope (r_envelope),
        .out_band     (r_band),
        .out_count    (r_count),
        .out_rms      (r_rms),
        .out_fresh    (m_tuser)
    );

    assign m_tdata = M_TDATA_W'({r_rms, r_count, r_band, r_envelope, r_filtered});

endmodule
